FILE: hdl/skc_pkg.sv
// shared types, constants and helpers for the sorted key set
`timescale 1ns / 1ps
`default_nettype none

package skc_pkg;

  // store geometry
  localparam int CAPACITY  = 32;
  localparam int KEY_WIDTH = 32;
  localparam int IN_KEY_W  = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_W     = 6;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // operation codes
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
    key_t key;
  } cell_cmd_t;

  // compare flags reported by a cell
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_st_t;

  // sign-extend or wrap to the store width, then flip the sign bit so
  // unsigned order matches signed order
  function automatic key_t bias_key(input logic signed [IN_KEY_W-1:0] raw);
    logic signed [KEY_WIDTH-1:0] ext;
    ext = KEY_WIDTH'(raw);
    return key_t'(ext) ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/skc_if.sv
// handshake channels for operation and result words
`timescale 1ns / 1ps
`default_nettype none

interface skc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [31:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface skc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] position;
  logic [5:0] count;

  modport source (output valid, output status, output position, output count,
                  input ready);
  modport sink   (input valid, input status, input position, input count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/skc_cell.sv
// one key cell: holds a key, compares it and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module skc_cell
  import skc_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_cmd_t cmd_i,
  input  wire logic      valid_i,
  input  wire logic      left_lt_i,
  input  wire key_t      left_key_i,
  input  wire key_t      right_key_i,
  output key_t           key_o,
  output cell_st_t       st_o
);

  key_t key_r;
  key_t key_nxt;
  logic lt;

  // compare against the broadcast key
  assign lt        = valid_i && (key_r < cmd_i.key);
  assign st_o.lt   = lt;
  assign st_o.eq   = valid_i && (key_r == cmd_i.key);
  assign key_o     = key_r;

  // insert opens a hole at the boundary, delete closes it
  always_comb begin
    key_nxt = key_r;
    if (cmd_i.ins_en) begin
      if (!left_lt_i) begin
        key_nxt = left_key_i;
      end else if (!lt) begin
        key_nxt = cmd_i.key;
      end
    end else if (cmd_i.del_en) begin
      if (!lt) begin
        key_nxt = right_key_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/sorted_key_set_core.sv
// Sorted key set: up to CAPACITY distinct signed keys kept in ascending order in a
// row of key cells. Each operation word (insert, delete, lookup, clear) gives one
// result word with status, rank and count. Each word is first registered in the
// operation stage; when it fires, every cell compares against the key at once and
// the row shifts by one place for insert or delete. A new word is accepted once the
// previous operation has moved to the output register; a result left waiting in
// the output register holds the operation stage until it is taken. No clearing
// pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_set_core
  import skc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  skc_in_if.sink      in_ch,
  skc_out_if.source   out_ch
);

  // operation stage
  logic    op_valid_r;
  mode_t   op_mode_r;
  key_t    op_key_r;
  logic    fire;

  // store state
  cnt_t    count_r;
  cnt_t    count_nxt;

  // output register
  logic    out_valid_r;
  status_t out_status_r;
  cnt_t    out_pos_r;
  cnt_t    out_count_r;
  status_t status_nxt;
  cnt_t    pos_nxt;

  // cell row
  cell_cmd_t            cmd;
  cell_st_t             st    [CAPACITY];
  key_t                 keys  [CAPACITY];
  logic [CAPACITY-1:0]  lt_vec;
  logic [CAPACITY-1:0]  eq_vec;
  logic [CAPACITY:0]    bnd;
  cnt_t                 rank;
  logic                 present;
  logic                 full;

  // accept a word while no operation is pending
  assign in_ch.ready = !op_valid_r;
  assign fire        = op_valid_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      op_valid_r <= 1'b1;
    end else if (fire) begin
      op_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_mode_r <= mode_t'(in_ch.mode);
      op_key_r  <= bias_key(in_ch.key);
    end
  end

  // the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic vld;
    logic left_lt;
    key_t left_key;
    key_t right_key;

    assign vld       = cnt_t'(i) < count_r;
    assign left_lt   = (i == 0) ? 1'b1 : st[(i == 0) ? 0 : i-1].lt;
    assign left_key  = (i == 0) ? op_key_r : keys[(i == 0) ? 0 : i-1];
    assign right_key = (i == CAPACITY-1) ? keys[i] : keys[(i == CAPACITY-1) ? i : i+1];
    assign lt_vec[i] = st[i].lt;
    assign eq_vec[i] = st[i].eq;

    skc_cell u_cell (
      .clk         (clk),
      .cmd_i       (cmd),
      .valid_i     (vld),
      .left_lt_i   (left_lt),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (keys[i]),
      .st_o        (st[i])
    );
  end

  // rank from the boundary of the less-than thermometer
  always_comb begin
    bnd[0]        = !lt_vec[0];
    bnd[CAPACITY] = lt_vec[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      bnd[i] = lt_vec[i-1] && !lt_vec[i];
    end
    rank = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (bnd[i]) begin
        rank = rank | cnt_t'(i);
      end
    end
  end

  assign present = |eq_vec;
  assign full    = (count_r == cnt_t'(CAPACITY));

  // decide the operation and drive the cells
  always_comb begin
    cmd.ins_en = 1'b0;
    cmd.del_en = 1'b0;
    cmd.key    = op_key_r;
    status_nxt = ST_OK;
    pos_nxt    = rank;
    count_nxt  = count_r;
    case (op_mode_r)
      MODE_INSERT: begin
        if (present) begin
          status_nxt = ST_MISS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins_en = fire;
          count_nxt  = count_r + cnt_t'(1);
        end
      end
      MODE_DELETE: begin
        if (!present) begin
          status_nxt = ST_MISS;
        end else begin
          cmd.del_en = fire;
          count_nxt  = count_r - cnt_t'(1);
        end
      end
      MODE_LOOKUP: begin
        status_nxt = present ? ST_OK : ST_MISS;
      end
      MODE_CLEAR: begin
        pos_nxt    = '0;
        count_nxt  = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // key count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_pos_r    <= pos_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.position = OUT_W'(out_pos_r);
  assign out_ch.count    = OUT_W'(out_count_r);

endmodule

`default_nettype wire

FILE: hdl/skc_checker.sv
// port-level checks for the sorted key set, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module skc_checker
  import skc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [5:0] out_position,
  input wire logic [5:0] out_count
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_position) && $stable(out_count))
    else $error("result word changed while stalled");

  // rank never lies past the count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= out_count)
    else $error("position beyond count");

  // full status only with a full store
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'(ST_FULL) |-> out_count == OUT_W'(CAPACITY))
    else $error("full reported below capacity");

  // count stays within capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= OUT_W'(CAPACITY))
    else $error("count above capacity");

  // no result word right after reset
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind sorted_key_set_core skc_checker u_skc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_position (out_ch.position),
  .out_count    (out_ch.count)
);

`default_nettype wire
